[hw/rtl/tnd_pkg.sv]
// Shared types and constants for the thumbnail nearest-neighbor downscaler.
// No dependencies; every other file in hw/rtl but tnd_fifo refers to this package.
`timescale 1ns / 1ps

package tnd_pkg;

  // File header: 4 magic bytes, 32-bit width, 32-bit height.
  localparam int HdrBytes = 12;

  // Width of the dimension and area fields carried between the front and back
  // ends. Sized for the largest supported image edge of 4096.
  localparam int DimW  = 13;
  localparam int AreaW = 25;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StMagic  = 2'd1,
    StDims   = 2'd2,
    StLength = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_bgra;
    logic        pixel_valid;
    logic        last_pixel;
    logic        done_res;
    status_e     status;
  } out_t;

  // One classified event from the front end: a finished source pixel, the end
  // of the file, or both.
  typedef struct packed {
    logic [31:0]      pix;
    logic             pix_ev;
    logic             done;
    status_e          status;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  edge_len;
    logic [AreaW-1:0] area;
  } ent_t;

  // Magic "K3T1", one byte per header position.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h4B;
      2'd1:    m = 8'h33;
      2'd2:    m = 8'h54;
      default: m = 8'h31;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/tnd_fifo.sv]
// Small register FIFO used between front and back ends and at the result side.
// Depends on nothing.
`timescale 1ns / 1ps

module tnd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/tnd_front.sv]
// Front end: header parse, error tracking, pixel assembly and end-of-file status.
// Depends on tnd_pkg. Holds the edge request register.
`timescale 1ns / 1ps

module tnd_front #(
  parameter int MAX_EDGE = 512,
  parameter int MIN_EDGE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  tnd_pkg::in_t      in_data_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  output logic              ent_push_o,
  output tnd_pkg::ent_t     ent_o
);

  localparam int WW = $clog2(MAX_EDGE + 1);
  localparam int AW = $clog2(MAX_EDGE * MAX_EDGE + 1);
  localparam int PW = $clog2(tnd_pkg::HdrBytes + 4 * MAX_EDGE * MAX_EDGE + 2);

  logic [PW-1:0]    pos_q, pos_d, pos_n;
  logic [31:0]      hdr_q, hdr_d, hdr_sh;
  logic [WW-1:0]    wid_q, wid_d, edge_q, edge_d, edge_c;
  logic [23:0]      asm_q, asm_d;
  tnd_pkg::status_e err_q, err_d, err_n, st;
  logic [PW-1:0]    endp_q;
  logic [AW-1:0]    area_q;
  logic [15:0]      req_q, req_lo;
  logic [2*WW-1:0]  sq, ew;
  logic [7:0]       b;
  logic             pix_ev, hdr_bad;

  assign b      = in_data_i.data_byte;
  assign hdr_sh = {b, hdr_q[31:8]};
  assign hdr_bad = (hdr_sh == 32'd0) || (hdr_sh > 32'(MAX_EDGE));
  assign req_lo = (req_q < 16'(MIN_EDGE)) ? 16'(MIN_EDGE) : req_q;
  assign edge_c = (req_lo > 16'(wid_q)) ? wid_q : req_lo[WW-1:0];
  assign sq     = (2*WW)'(wid_q) * (2*WW)'(wid_q);
  assign ew     = (2*WW)'(edge_q) * (2*WW)'(wid_q);

  always_comb begin
    pos_d  = pos_q;
    hdr_d  = hdr_q;
    wid_d  = wid_q;
    edge_d = edge_q;
    asm_d  = asm_q;
    err_n  = err_q;
    st     = tnd_pkg::StOk;
    pix_ev = 1'b0;
    pos_n  = (pos_q == '1) ? pos_q : pos_q + 1'b1;
    if (in_fire_i) begin
      if (pos_q < PW'(4)) begin
        if (b != tnd_pkg::magic_byte(pos_q[1:0]) && err_q == tnd_pkg::StOk) begin
          err_n = tnd_pkg::StMagic;
        end
      end else if (pos_q < PW'(tnd_pkg::HdrBytes)) begin
        hdr_d = hdr_sh;
        if (pos_q == PW'(7) && err_q == tnd_pkg::StOk) begin
          if (hdr_bad) begin
            err_n = tnd_pkg::StDims;
          end else begin
            wid_d = hdr_sh[WW-1:0];
          end
        end else if (pos_q == PW'(11) && err_q == tnd_pkg::StOk) begin
          if (hdr_bad || hdr_sh != 32'(wid_q)) begin
            err_n = tnd_pkg::StDims;
          end else begin
            edge_d = edge_c;
          end
        end
      end else if (err_q == tnd_pkg::StOk && pos_q < endp_q) begin
        // pixel data starts on a 4-byte boundary, so the low bits are the lane
        case (pos_q[1:0])
          2'd0:    asm_d[7:0]   = b;
          2'd1:    asm_d[15:8]  = b;
          2'd2:    asm_d[23:16] = b;
          default: begin
            pix_ev = 1'b1;
            asm_d  = '0;
          end
        endcase
      end
      pos_d = pos_n;
      if (in_data_i.last_byte) begin
        st = err_n;
        if (st == tnd_pkg::StOk &&
            (pos_n < PW'(tnd_pkg::HdrBytes) || pos_n != endp_q)) begin
          st = tnd_pkg::StLength;
        end
        pos_d  = '0;
        hdr_d  = '0;
        wid_d  = '0;
        edge_d = '0;
        asm_d  = '0;
        err_n  = tnd_pkg::StOk;
      end
    end
    err_d = err_n;
  end

  assign ent_push_o      = in_fire_i & (pix_ev | in_data_i.last_byte);
  assign ent_o.pix       = {b, asm_q};
  assign ent_o.pix_ev    = pix_ev;
  assign ent_o.done      = in_data_i.last_byte;
  assign ent_o.status    = st;
  assign ent_o.width     = tnd_pkg::DimW'(wid_q);
  assign ent_o.edge_len  = tnd_pkg::DimW'(edge_q);
  assign ent_o.area      = tnd_pkg::AreaW'(area_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hdr_q  <= '0;
      wid_q  <= '0;
      edge_q <= '0;
      asm_q  <= '0;
      err_q  <= tnd_pkg::StOk;
      endp_q <= '0;
      area_q <= '0;
      req_q  <= 16'd256;
    end else begin
      pos_q  <= pos_d;
      hdr_q  <= hdr_d;
      wid_q  <= wid_d;
      edge_q <= edge_d;
      asm_q  <= asm_d;
      err_q  <= err_d;
      // file length and edge*width are registered from the stored header fields;
      // neither is needed before the pixel bytes start
      endp_q <= PW'(tnd_pkg::HdrBytes) + PW'({sq, 2'b00});
      area_q <= AW'(ew);
      if (cfg_we_i) begin
        req_q <= cfg_data_i;
      end
    end
  end

endmodule

[hw/rtl/tnd_back.sv]
// Back end: nearest-neighbor row/column selection by running compares.
// Depends on tnd_pkg. Emits at most one result per cycle, while the result FIFO has room.
`timescale 1ns / 1ps

module tnd_back #(
  parameter int MAX_EDGE = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ent_valid_i,
  input  tnd_pkg::ent_t ent_i,
  output logic          ent_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output tnd_pkg::out_t res_o
);

  localparam int WW = $clog2(MAX_EDGE + 1);
  localparam int CW = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
  localparam int AW = $clog2(MAX_EDGE * MAX_EDGE + 1);

  typedef enum logic [1:0] {
    BkPixel  = 2'b01,
    BkStatus = 2'b10
  } bk_state_e;

  bk_state_e     state_q, state_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] ctgt_q, ctgt_d, cbase_q, cbase_d, rtgt_q, rtgt_d, rbase_q, rbase_d;
  logic [AW:0]   w_x, e_x, area_x;
  logic [WW-1:0] w_n;
  logic          go, row_sel, col_sel, sel, lp, col_end;

  assign w_n    = ent_i.width[WW-1:0];
  assign w_x    = (AW+1)'(w_n);
  assign e_x    = (AW+1)'(ent_i.edge_len[WW-1:0]);
  assign area_x = (AW+1)'(ent_i.area[AW-1:0]);
  assign go     = ent_valid_i & ~res_full_i;

  assign row_sel = {1'b0, rtgt_q} < ({1'b0, rbase_q} + e_x);
  assign col_sel = {1'b0, ctgt_q} < ({1'b0, cbase_q} + e_x);
  assign sel     = ent_i.pix_ev & row_sel & col_sel;
  assign lp      = (({1'b0, ctgt_q} + w_x) == area_x) && (({1'b0, rtgt_q} + w_x) == area_x);
  assign col_end = (WW'(col_q) + 1'b1) >= w_n;

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    ctgt_d     = ctgt_q;
    cbase_d    = cbase_q;
    rtgt_d     = rtgt_q;
    rbase_d    = rbase_q;
    ent_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    if (go) begin
      case (state_q)
        BkStatus: begin
          res_push_o     = 1'b1;
          res_o.done_res = 1'b1;
          res_o.status   = ent_i.status;
          ent_pop_o      = 1'b1;
          state_d        = BkPixel;
          col_d   = '0;
          ctgt_d  = '0;
          cbase_d = '0;
          rtgt_d  = '0;
          rbase_d = '0;
        end
        default: begin
          if (ent_i.pix_ev) begin
            if (sel) begin
              res_push_o        = 1'b1;
              res_o.pixel_bgra  = ent_i.pix;
              res_o.pixel_valid = 1'b1;
              res_o.last_pixel  = lp;
              ctgt_d            = AW'({1'b0, ctgt_q} + w_x);
            end
            cbase_d = AW'({1'b0, cbase_q} + e_x);
            if (col_end) begin
              col_d   = '0;
              ctgt_d  = '0;
              cbase_d = '0;
              if (row_sel) begin
                rtgt_d = AW'({1'b0, rtgt_q} + w_x);
              end
              rbase_d = AW'({1'b0, rbase_q} + e_x);
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          if (ent_i.done && sel) begin
            // pixel and status in one event: the status goes out later, from BkStatus
            state_d = BkStatus;
          end else begin
            ent_pop_o = 1'b1;
            if (ent_i.done) begin
              res_push_o     = 1'b1;
              res_o          = '0;
              res_o.done_res = 1'b1;
              res_o.status   = ent_i.status;
              col_d   = '0;
              ctgt_d  = '0;
              cbase_d = '0;
              rtgt_d  = '0;
              rbase_d = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkPixel;
      col_q   <= '0;
      ctgt_q  <= '0;
      cbase_q <= '0;
      rtgt_q  <= '0;
      rbase_q <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      ctgt_q  <= ctgt_d;
      cbase_q <= cbase_d;
      rtgt_q  <= rtgt_d;
      rbase_q <= rbase_d;
    end
  end

endmodule

[hw/rtl/thumbnail_nearest_downscaler_unit.sv]
// Top level of the thumbnail nearest-neighbor downscaler.
// Depends on tnd_pkg, tnd_front, tnd_back and tnd_fifo.
//
//   channel   direction  handshake                  beat
//   --------  ---------  -------------------------  ----------------------------
//   input     in         push / full                one file byte (in_data_i)
//   result    out        empty / pop                one pixel or status result
//   config    in         cfg_valid_i / cfg_ready_o  requested edge (cfg_data_i)
//
// Input: one byte per clock is taken while full is low. A result reaches the
//   output ports through the event queue, then the registered result FIFO,
//   and can be popped once empty is low.
// The back end moves one result per clock while the result FIFO has room; a
//   file ending in a selected pixel adds a BkStatus pass the queue absorbs.
// Reset clears all control state; the requested edge returns to 256.
// Stalls: pop low fills the result FIFO, then the event queue; full rises
//   only once QUEUE_DEPTH events are waiting.
`timescale 1ns / 1ps

module thumbnail_nearest_downscaler_unit #(
  parameter int MAX_EDGE    = 512,
  parameter int MIN_EDGE    = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  tnd_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output tnd_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);

  localparam int EntW = $bits(tnd_pkg::ent_t);
  localparam int ResW = $bits(tnd_pkg::out_t);

  logic           in_fire;
  logic           ent_push, ent_pop, ent_empty;
  tnd_pkg::ent_t  ent_w, ent_r;
  logic [EntW-1:0] ent_rd;
  logic           res_push, res_full;
  tnd_pkg::out_t  res_w;
  logic [ResW-1:0] res_rd;

  // register writes are only legal while idle, so the port never stalls
  assign cfg_ready_o = 1'b1;
  assign in_fire     = push & ~full;

  tnd_front #(
    .MAX_EDGE (MAX_EDGE),
    .MIN_EDGE (MIN_EDGE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ent_push_o (ent_push),
    .ent_o      (ent_w)
  );

  // event queue between classification and selection
  tnd_fifo #(
    .Width (EntW),
    .Depth (QUEUE_DEPTH)
  ) u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ent_push),
    .wdata_i (ent_w),
    .pop_i   (ent_pop),
    .rdata_o (ent_rd),
    .full_o  (full),
    .empty_o (ent_empty)
  );

  assign ent_r = ent_rd;

  tnd_back #(
    .MAX_EDGE (MAX_EDGE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (~ent_empty),
    .ent_i       (ent_r),
    .ent_pop_o   (ent_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_w)
  );

  // result FIFO keeps the back end running while the consumer holds off
  tnd_fifo #(
    .Width (ResW),
    .Depth (2)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_w),
    .pop_i   (pop),
    .rdata_o (res_rd),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign out_data_o = res_rd;

endmodule

[hw/rtl/tnd_checker.sv]
// Port-level checks for thumbnail_nearest_downscaler_unit, with its bind.
// Depends on tnd_pkg.
`timescale 1ns / 1ps

module tnd_prop_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input tnd_pkg::out_t out_data_o
);

  // a waiting result is not taken back or changed while pop is low
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.pixel_valid != out_data_o.done_res))
    else $error("result is neither or both pixel and status");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.done_res) |->
      (out_data_o.pixel_bgra == 32'd0 && !out_data_o.last_pixel))
    else $error("status result carries pixel fields");

  a_pixel_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.pixel_valid) |-> (out_data_o.status == tnd_pkg::StOk))
    else $error("pixel result carries a status");

  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("input side filled up without a push");

endmodule

bind thumbnail_nearest_downscaler_unit tnd_prop_checker u_tnd_checker (.*);
